// ===== hdl/cau_pkg.sv =====
// Shared types, constants and helper functions for the complex arithmetic unit.
package cau_pkg;

   localparam int FRAC_BITS = 16;
   localparam int QUO_BITS  = 33;
   localparam int HI_SHIFT  = QUO_BITS - FRAC_BITS;
   localparam logic [63:0] ROUND_HALF = 64'd1 << (FRAC_BITS - 1);

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_CMP = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      KIND_SIMPLE,
      KIND_MUL,
      KIND_DIV
   } kind_type;

   typedef struct packed {
      logic [31:0] re;
      logic [31:0] im;
      logic        eq;
      logic        zd;
      logic        ovf;
   } simple_type;

   typedef struct packed {
      logic [31:0] val;
      logic        ovf;
   } sat_type;

   // One result part on its way through the divider steps.
   typedef struct packed {
      logic                neg;
      logic                big;
      logic [63:0]         rem;
      logic [QUO_BITS-1:0] quo;
      logic [QUO_BITS-1:0] low;
   } part_type;

   typedef struct packed {
      logic       vld;
      kind_type   kind;
      logic [63:0] den;
      part_type   re;
      part_type   im;
      simple_type simple;
   } stage_type;

   function automatic sat_type sat_sum(input logic [32:0] v);
      sat_type s;
      s.ovf = (v[32] != v[31]);
      if (!s.ovf) begin
         s.val = v[31:0];
      end else if (v[32]) begin
         s.val = 32'h8000_0000;
      end else begin
         s.val = 32'h7FFF_FFFF;
      end
      return s;
   endfunction

   function automatic sat_type sat_mag(input logic neg, input logic [63:0] mag);
      sat_type     s;
      logic [63:0] n;
      n = 64'd0 - mag;
      s.ovf = 1'b0;
      if (neg) begin
         if (mag > 64'h8000_0000) begin
            s.ovf = 1'b1;
            s.val = 32'h8000_0000;
         end else begin
            s.val = n[31:0];
         end
      end else begin
         if (mag > 64'h7FFF_FFFF) begin
            s.ovf = 1'b1;
            s.val = 32'h7FFF_FFFF;
         end else begin
            s.val = mag[31:0];
         end
      end
      return s;
   endfunction

endpackage

// ===== hdl/cau_if.sv =====
// Request and response channel interfaces of the complex arithmetic unit.
interface cau_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic [31:0] a_real;
   logic [31:0] a_imag;
   logic [31:0] b_real;
   logic [31:0] b_imag;

   modport source (output valid, op, a_real, a_imag, b_real, b_imag, input ready);
   modport sink (input valid, op, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] res_real;
   logic [31:0] res_imag;
   logic        equal_flag;
   logic        zero_divisor;
   logic        overflow_flag;

   modport source (output valid, res_real, res_imag, equal_flag, zero_divisor,
                   overflow_flag, input ready);
   modport sink (input valid, res_real, res_imag, equal_flag, zero_divisor,
                 overflow_flag, output ready);
endinterface

// ===== hdl/complex_arithmetic_unit.sv =====
// Top level of the pipelined complex arithmetic unit.
//
//   channel    direction  contents
//   req_chan   in         op, a_real, a_imag, b_real, b_imag
//   rsp_chan   out        res_real, res_imag, equal_flag, zero_divisor, overflow_flag
//
// One transaction enters per cycle while the output register is not stalled;
// every operation takes the same path of 39 register stages (products, sums,
// magnitudes, divider setup, 33 divider steps, rounding, output). The 33
// one-bit steps of the quotient set the depth. Reset clears only the valid
// bits. A stalled output register freezes the whole pipeline.
module complex_arithmetic_unit (
   input  logic          clock,
   input  logic          reset,
   cau_req_if.sink       req_chan,
   cau_rsp_if.source     rsp_chan
);

   typedef struct packed {
      logic               vld;
      cau_pkg::op_type    op;
      logic [63:0]        ac;
      logic [63:0]        bd;
      logic [63:0]        ad;
      logic [63:0]        bc;
      logic [63:0]        cc;
      logic [63:0]        dd;
      logic [32:0]        sum_r;
      logic [32:0]        sum_i;
      logic               eq;
      logic               dzero;
   } s1_type;

   typedef struct packed {
      logic                vld;
      cau_pkg::kind_type   kind;
      logic [63:0]         den;
      logic [64:0]         sr;
      logic [64:0]         si;
      cau_pkg::simple_type simple;
   } s2_type;

   typedef struct packed {
      logic                vld;
      cau_pkg::kind_type   kind;
      logic [63:0]         den;
      logic                neg_r;
      logic [63:0]         mag_r;
      logic                neg_i;
      logic [63:0]         mag_i;
      cau_pkg::simple_type simple;
   } s3_type;

   typedef struct packed {
      logic                vld;
      cau_pkg::kind_type   kind;
      logic                neg_r;
      logic [63:0]         mag_r;
      logic                neg_i;
      logic [63:0]         mag_i;
      cau_pkg::simple_type simple;
   } s5_type;

   logic advance;

   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   cau_pkg::stage_type s4_ff, s4_in;
   cau_pkg::stage_type dchain [0:cau_pkg::QUO_BITS];
   s5_type s5_ff, s5_in;
   logic                rsp_vld_ff;
   cau_pkg::simple_type rsp_ff, rsp_in;

   logic signed [31:0] sa, sb, sc, sd;
   logic signed [63:0] p_ac, p_bd, p_ad, p_bc, p_cc, p_dd;

   assign advance        = !rsp_vld_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   // Stage 1: products and the short sums.
   assign sa = req_chan.a_real;
   assign sb = req_chan.a_imag;
   assign sc = req_chan.b_real;
   assign sd = req_chan.b_imag;
   assign p_ac = sa * sc;
   assign p_bd = sb * sd;
   assign p_ad = sa * sd;
   assign p_bc = sb * sc;
   assign p_cc = sc * sc;
   assign p_dd = sd * sd;

   always_comb begin
      s1_in.vld   = req_chan.valid;
      s1_in.op    = cau_pkg::op_type'(req_chan.op);
      s1_in.ac    = p_ac;
      s1_in.bd    = p_bd;
      s1_in.ad    = p_ad;
      s1_in.bc    = p_bc;
      s1_in.cc    = p_cc;
      s1_in.dd    = p_dd;
      if (req_chan.op == cau_pkg::OP_SUB) begin
         s1_in.sum_r = {sa[31], sa} - {sc[31], sc};
         s1_in.sum_i = {sb[31], sb} - {sd[31], sd};
      end else begin
         s1_in.sum_r = {sa[31], sa} + {sc[31], sc};
         s1_in.sum_i = {sb[31], sb} + {sd[31], sd};
      end
      s1_in.eq    = (sa == sc) && (sb == sd);
      s1_in.dzero = (sc == 32'sd0) && (sd == 32'sd0);
   end

   // Stage 2: sums of products, divisor, finished short results.
   always_comb begin
      cau_pkg::sat_type sat_r;
      cau_pkg::sat_type sat_i;
      sat_r = cau_pkg::sat_sum(s1_ff.sum_r);
      sat_i = cau_pkg::sat_sum(s1_ff.sum_i);
      s2_in.vld    = s1_ff.vld;
      s2_in.kind   = cau_pkg::KIND_SIMPLE;
      s2_in.den    = s1_ff.cc + s1_ff.dd;
      s2_in.sr     = {s1_ff.ac[63], s1_ff.ac} + {s1_ff.bd[63], s1_ff.bd};
      s2_in.si     = {s1_ff.bc[63], s1_ff.bc} - {s1_ff.ad[63], s1_ff.ad};
      s2_in.simple = '0;
      case (s1_ff.op)
         cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
            s2_in.simple.re  = sat_r.val;
            s2_in.simple.im  = sat_i.val;
            s2_in.simple.ovf = sat_r.ovf | sat_i.ovf;
         end
         cau_pkg::OP_MUL: begin
            s2_in.kind = cau_pkg::KIND_MUL;
            s2_in.sr   = {s1_ff.ac[63], s1_ff.ac} - {s1_ff.bd[63], s1_ff.bd};
            s2_in.si   = {s1_ff.ad[63], s1_ff.ad} + {s1_ff.bc[63], s1_ff.bc};
         end
         cau_pkg::OP_DIV: begin
            if (s1_ff.dzero) begin
               s2_in.simple.zd = 1'b1;
            end else begin
               s2_in.kind = cau_pkg::KIND_DIV;
            end
         end
         cau_pkg::OP_CMP: begin
            s2_in.simple.eq = s1_ff.eq;
         end
         default: begin
            s2_in.simple = '0;
         end
      endcase
   end

   // Stage 3: sign and magnitude.
   always_comb begin
      logic [64:0] nr;
      logic [64:0] ni;
      nr = 65'd0 - s2_ff.sr;
      ni = 65'd0 - s2_ff.si;
      s3_in.vld    = s2_ff.vld;
      s3_in.kind   = s2_ff.kind;
      s3_in.den    = s2_ff.den;
      s3_in.neg_r  = s2_ff.sr[64];
      s3_in.mag_r  = s2_ff.sr[64] ? nr[63:0] : s2_ff.sr[63:0];
      s3_in.neg_i  = s2_ff.si[64];
      s3_in.mag_i  = s2_ff.si[64] ? ni[63:0] : s2_ff.si[63:0];
      s3_in.simple = s2_ff.simple;
   end

   // Stage 4: rounding of products, or divider setup.
   function automatic cau_pkg::part_type setup(input cau_pkg::kind_type kind,
                                               input logic neg,
                                               input logic [63:0] mag,
                                               input logic [63:0] den);
      cau_pkg::part_type        p;
      logic [63:0]              rounded;
      logic [63:0]              hi;
      logic [63+cau_pkg::FRAC_BITS:0] shifted;
      rounded = (mag + cau_pkg::ROUND_HALF) >> cau_pkg::FRAC_BITS;
      hi      = mag >> cau_pkg::HI_SHIFT;
      shifted = {mag, {cau_pkg::FRAC_BITS{1'b0}}};
      p.neg = neg;
      p.quo = '0;
      if (kind == cau_pkg::KIND_DIV) begin
         // The quotient needs more than its bits when the top of the
         // dividend already reaches the divisor.
         p.big = (hi >= den);
         p.rem = hi;
         p.low = shifted[cau_pkg::QUO_BITS-1:0];
      end else begin
         p.big = 1'b0;
         p.rem = rounded;
         p.low = '0;
      end
      return p;
   endfunction

   always_comb begin
      s4_in.vld    = s3_ff.vld;
      s4_in.kind   = s3_ff.kind;
      s4_in.den    = s3_ff.den;
      s4_in.re     = setup(s3_ff.kind, s3_ff.neg_r, s3_ff.mag_r, s3_ff.den);
      s4_in.im     = setup(s3_ff.kind, s3_ff.neg_i, s3_ff.mag_i, s3_ff.den);
      s4_in.simple = s3_ff.simple;
   end

   assign dchain[0] = s4_ff;

   for (genvar i = 0; i < cau_pkg::QUO_BITS; i++) begin : g_div
      cau_div_stage u_step (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .stage_in  (dchain[i]),
         .stage_out (dchain[i+1])
      );
   end

   // Stage 5: final magnitude with quotient rounding.
   function automatic logic [63:0] final_mag(input cau_pkg::kind_type kind,
                                             input cau_pkg::part_type p,
                                             input logic [63:0] den);
      logic        rnd;
      logic [63:0] q;
      rnd = ({p.rem, 1'b0} >= {1'b0, den});
      q   = {{(64-cau_pkg::QUO_BITS){1'b0}}, p.quo} + {63'd0, rnd};
      if (kind == cau_pkg::KIND_DIV) begin
         return p.big ? {64{1'b1}} : q;
      end
      return p.rem;
   endfunction

   always_comb begin
      cau_pkg::stage_type last;
      last = dchain[cau_pkg::QUO_BITS];
      s5_in.vld    = last.vld;
      s5_in.kind   = last.kind;
      s5_in.neg_r  = last.re.neg;
      s5_in.mag_r  = final_mag(last.kind, last.re, last.den);
      s5_in.neg_i  = last.im.neg;
      s5_in.mag_i  = final_mag(last.kind, last.im, last.den);
      s5_in.simple = last.simple;
   end

   // Output stage: saturation.
   always_comb begin
      cau_pkg::sat_type sat_r;
      cau_pkg::sat_type sat_i;
      sat_r = cau_pkg::sat_mag(s5_ff.neg_r, s5_ff.mag_r);
      sat_i = cau_pkg::sat_mag(s5_ff.neg_i, s5_ff.mag_i);
      if (s5_ff.kind == cau_pkg::KIND_SIMPLE) begin
         rsp_in = s5_ff.simple;
      end else begin
         rsp_in.re  = sat_r.val;
         rsp_in.im  = sat_i.val;
         rsp_in.eq  = 1'b0;
         rsp_in.zd  = 1'b0;
         rsp_in.ovf = sat_r.ovf | sat_i.ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.vld  <= 1'b0;
         s2_ff.vld  <= 1'b0;
         s3_ff.vld  <= 1'b0;
         s4_ff.vld  <= 1'b0;
         s5_ff.vld  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_ff      <= s1_in;
         s2_ff      <= s2_in;
         s3_ff      <= s3_in;
         s4_ff      <= s4_in;
         s5_ff      <= s5_in;
         rsp_ff     <= rsp_in;
         rsp_vld_ff <= s5_ff.vld;
      end
   end

   assign rsp_chan.valid         = rsp_vld_ff;
   assign rsp_chan.res_real      = rsp_ff.re;
   assign rsp_chan.res_imag      = rsp_ff.im;
   assign rsp_chan.equal_flag    = rsp_ff.eq;
   assign rsp_chan.zero_divisor  = rsp_ff.zd;
   assign rsp_chan.overflow_flag = rsp_ff.ovf;

endmodule

// ===== hdl/cau_div_stage.sv =====
// One restoring division step for both result parts, registered.
module cau_div_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  cau_pkg::stage_type stage_in,
   output cau_pkg::stage_type stage_out
);

   cau_pkg::stage_type stage_ff;
   cau_pkg::stage_type stage_in_next;

   function automatic cau_pkg::part_type step(input cau_pkg::part_type p,
                                              input logic [63:0] den);
      cau_pkg::part_type q;
      logic [64:0]       r2;
      logic [64:0]       diff;
      logic              ge;
      q    = p;
      r2   = {p.rem, p.low[cau_pkg::QUO_BITS-1]};
      diff = r2 - {1'b0, den};
      ge   = (r2 >= {1'b0, den});
      q.rem = ge ? diff[63:0] : r2[63:0];
      q.quo = {p.quo[cau_pkg::QUO_BITS-2:0], ge};
      q.low = {p.low[cau_pkg::QUO_BITS-2:0], 1'b0};
      return q;
   endfunction

   always_comb begin
      stage_in_next = stage_in;
      if (stage_in.kind == cau_pkg::KIND_DIV) begin
         stage_in_next.re = step(stage_in.re, stage_in.den);
         stage_in_next.im = step(stage_in.im, stage_in.den);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.vld <= 1'b0;
      end else if (enable) begin
         stage_ff <= stage_in_next;
      end
   end

   assign stage_out = stage_ff;

endmodule
